// ----- src/ndc_pkg.sv -----
// Package for the nutrient dosing controller.
// Holds widths, register indexes, reset values and the dosing phase codes.
// Depends on nothing.
package ndc_pkg;

    localparam int WINDOW_LEN = 20;

    localparam int DATA_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int HELD_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = DATA_W + HELD_W;
    localparam int REM_W   = HELD_W + 1;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPENSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX       = 2'd2;

    localparam logic [DATA_W-1:0] THRESHOLD_RESET = 16'd3840;
    localparam logic [DATA_W-1:0] DISPENSE_RESET  = 16'd2000;
    localparam logic [DATA_W-1:0] MIX_RESET       = 16'd10000;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DISPENSE = 2'd1,
        PH_MIX      = 2'd2
    } t_phase;

endpackage

// ----- src/ndc_in_if.sv -----
// Input channel of the nutrient dosing controller: one sample and its timestamp.
// Depends on ndc_pkg.
interface ndc_in_if;
    import ndc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink (input valid, input sample, input now_ms, output ready);
endinterface

// ----- src/ndc_out_if.sv -----
// Result channel of the nutrient dosing controller: mean level, pump and phase.
// Depends on ndc_pkg.
interface ndc_out_if;
    import ndc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] mean_level;
    logic              pump_on;
    logic [1:0]        phase;

    modport source (output valid, output mean_level, output pump_on, output phase,
                    input ready);
    modport sink (input valid, input mean_level, input pump_on, input phase,
                  output ready);
endinterface

// ----- src/nutrient_dosing_controller.sv -----
// Nutrient dosing controller: moving average of conductivity and a timed dosing sequencer.
// Depends on ndc_pkg, ndc_in_if and ndc_out_if.
// Each accepted item is written into a ring of WINDOW_LEN samples and the running sum is
// updated; the mean is then found by a restoring divider that produces one quotient bit a
// cycle. The block takes no new item until the result of the last one is registered in the
// output register. The result waits in that register, so a stalled consumer holds the block
// only when that register is still full at the end of the next item.
module nutrient_dosing_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ndc_in_if.sink                         i_in,
    ndc_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ndc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ndc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ndc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_DIV,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_mem [WINDOW_LEN];

    logic [DATA_W-1:0] r_threshold;
    logic [DATA_W-1:0] r_disp_time;
    logic [DATA_W-1:0] r_mix_time;

    logic [SLOT_W-1:0] r_slot;
    logic              r_full;
    logic              r_was_full;
    logic [HELD_W-1:0] r_held;
    logic [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0] r_sample;
    logic [DATA_W-1:0] r_old;
    logic [TIME_W-1:0] r_now;
    logic [SUM_W-1:0]  r_dq;
    logic [REM_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    t_phase            r_phase;
    logic [TIME_W-1:0] r_phase_start;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_mean;
    logic              r_pump;
    t_phase            r_phase_out;

    logic              n_last_slot;
    logic [REM_W-1:0]  n_trial;
    logic              n_qbit;
    logic [TIME_W-1:0] n_elapsed;
    logic [DATA_W-1:0] n_mean;
    t_phase            n_phase;
    logic              n_restart;
    logic              n_out_free;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.mean_level = r_mean;
    assign o_out.pump_on    = r_pump;
    assign o_out.phase      = r_phase_out;

    assign n_last_slot = (r_slot == SLOT_W'(WINDOW_LEN - 1));
    assign n_trial     = {r_rem[HELD_W-1:0], r_dq[SUM_W-1]};
    assign n_qbit      = (n_trial >= {1'b0, r_held});
    assign n_elapsed   = r_now - r_phase_start;
    assign n_mean      = r_dq[DATA_W-1:0];
    assign n_out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        n_phase   = r_phase;
        n_restart = 1'b0;
        case (r_phase)
            PH_DISPENSE: begin
                if (n_elapsed >= {{(TIME_W-DATA_W){1'b0}}, r_disp_time}) begin
                    n_phase   = PH_MIX;
                    n_restart = 1'b1;
                end
            end
            PH_MIX: begin
                if (n_elapsed >= {{(TIME_W-DATA_W){1'b0}}, r_mix_time}) begin
                    n_phase   = PH_IDLE;
                    n_restart = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if ((n_mean != '0) && (n_mean < r_threshold)) begin
                    n_phase   = PH_DISPENSE;
                    n_restart = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_old         <= r_mem[r_slot];
            r_mem[r_slot] <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_threshold   <= THRESHOLD_RESET;
            r_disp_time   <= DISPENSE_RESET;
            r_mix_time    <= MIX_RESET;
            r_slot        <= '0;
            r_full        <= 1'b0;
            r_sum         <= '0;
            r_phase       <= PH_IDLE;
            r_phase_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_DISPENSE:  r_disp_time <= i_cfg_data;
                    CFG_MIX:       r_mix_time  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sample   <= i_in.sample;
                        r_now      <= i_in.now_ms;
                        r_was_full <= r_full;
                        if (n_last_slot) begin
                            r_slot <= '0;
                            r_full <= 1'b1;
                            r_held <= HELD_W'(WINDOW_LEN);
                        end else begin
                            r_slot <= r_slot + 1'b1;
                            r_held <= r_full ? HELD_W'(WINDOW_LEN)
                                             : HELD_W'(r_slot) + 1'b1;
                        end
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (r_was_full) begin
                        r_sum <= r_sum - {{(SUM_W-DATA_W){1'b0}}, r_old};
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum   <= r_sum + {{(SUM_W-DATA_W){1'b0}}, r_sample};
                    r_dq    <= r_sum + {{(SUM_W-DATA_W){1'b0}}, r_sample};
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= n_qbit ? (n_trial - {1'b0, r_held}) : n_trial;
                    r_dq   <= {r_dq[SUM_W-2:0], n_qbit};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (n_out_free) begin
                        r_phase     <= n_phase;
                        if (n_restart) begin
                            r_phase_start <= r_now;
                        end
                        r_out_valid <= 1'b1;
                        r_mean      <= n_mean;
                        r_pump      <= (n_phase == PH_DISPENSE);
                        r_phase_out <= n_phase;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/ndc_checker.sv -----
// Port-level checks for the nutrient dosing controller, and the bind that attaches them.
// Depends on ndc_pkg and on the ports of nutrient_dosing_controller.
module ndc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ndc_pkg::DATA_W-1:0] i_mean_level,
    input logic                      i_pump_on,
    input logic [1:0]                i_phase
);
    import ndc_pkg::*;

    // A result held back by the consumer keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_mean_level) && $stable(i_pump_on) && $stable(i_phase)))
        else $error("result changed while stalled");

    // The pump runs exactly when the phase reported is dispensing.
    a_pump_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pump_on == (i_phase == PH_DISPENSE)))
        else $error("pump state disagrees with phase");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // An accepted item occupies the block, so the next one is not taken at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while busy");

endmodule

bind nutrient_dosing_controller ndc_checker u_ndc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_mean_level (o_out.mean_level),
    .i_pump_on    (o_out.pump_on),
    .i_phase      (o_out.phase)
);

// ----- tb/ndc_dose_checker.sv -----
// Checker for the nutrient dosing controller: watches the sample, result and register
// channels, predicts every result and compares it field by field.
// Depends on ndc_pkg, ndc_in_if and ndc_out_if.
module ndc_dose_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ndc_in_if                              i_in,
    ndc_out_if                             i_out,
    input  logic                           i_cfg_we,
    input  logic [ndc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ndc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_failures,
    output int                             o_results_done,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ndc_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [DATA_W-1:0] mean_level;
        logic              pump_on;
        t_phase            phase;
    } t_dose_outcome;

    t_dose_outcome     outcomes_due[$];
    logic [DATA_W-1:0] level_ring [WINDOW_LEN];
    int                ring_slot;
    logic              ring_full;
    logic [SUM_W-1:0]  level_sum;
    t_phase            dose_step;
    logic [TIME_W-1:0] step_started;
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] dispense_ms;
    logic [DATA_W-1:0] mix_ms;
    int                failures = 0;
    int                results_done = 0;

    task automatic note_failure(input string what);
        if (failures < PRINT_CAP) begin
            $display("[%0t] dose result mismatch: %s", $realtime, what);
        end
        failures++;
    endtask

    function automatic t_dose_outcome predict_dose(input logic [DATA_W-1:0] level,
                                                   input logic [TIME_W-1:0] stamp);
        t_dose_outcome     outcome;
        logic [TIME_W-1:0] elapsed;
        int                held;
        if (ring_full) begin
            level_sum = level_sum - level_ring[ring_slot];
        end
        level_ring[ring_slot] = level;
        level_sum = level_sum + level;
        if (ring_slot == WINDOW_LEN - 1) begin
            ring_slot = 0;
            ring_full = 1'b1;
        end else begin
            ring_slot = ring_slot + 1;
        end
        held = ring_full ? WINDOW_LEN : ring_slot;
        outcome.mean_level = DATA_W'(level_sum / held);

        elapsed = stamp - step_started;
        case (dose_step)
            PH_DISPENSE: begin
                if (elapsed >= dispense_ms) begin
                    step_started = stamp;
                    dose_step = PH_MIX;
                end
            end
            PH_MIX: begin
                if (elapsed >= mix_ms) begin
                    step_started = stamp;
                    dose_step = PH_IDLE;
                end
            end
            default: begin
                dose_step = PH_IDLE;
                if (outcome.mean_level != '0 && outcome.mean_level < threshold) begin
                    step_started = stamp;
                    dose_step = PH_DISPENSE;
                end
            end
        endcase
        outcome.phase = dose_step;
        outcome.pump_on = (dose_step == PH_DISPENSE);
        return outcome;
    endfunction

    always @(posedge i_clk) begin
        t_dose_outcome want;
        if (!i_rst_n) begin
            outcomes_due.delete();
            ring_slot = 0;
            ring_full = 1'b0;
            level_sum = '0;
            dose_step = PH_IDLE;
            step_started = '0;
            threshold = THRESHOLD_RESET;
            dispense_ms = DISPENSE_RESET;
            mix_ms = MIX_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: threshold = i_cfg_data;
                    CFG_DISPENSE:  dispense_ms = i_cfg_data;
                    CFG_MIX:       mix_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                outcomes_due.push_back(predict_dose(i_in.sample, i_in.now_ms));
            end
            if (i_out.valid && i_out.ready) begin
                results_done++;
                if (outcomes_due.size() == 0) begin
                    note_failure($sformatf("result with mean %0d and phase %0d arrived unasked",
                                           i_out.mean_level, i_out.phase));
                end else begin
                    want = outcomes_due.pop_front();
                    if (i_out.mean_level !== want.mean_level) begin
                        note_failure($sformatf("mean_level %0d, expected %0d",
                                               i_out.mean_level, want.mean_level));
                    end
                    if (i_out.pump_on !== want.pump_on) begin
                        note_failure($sformatf("pump_on %0b, expected %0b",
                                               i_out.pump_on, want.pump_on));
                    end
                    if (i_out.phase !== want.phase) begin
                        note_failure($sformatf("phase %0d, expected %0d",
                                               i_out.phase, want.phase));
                    end
                end
            end
        end
        o_failures <= failures;
        o_results_done <= results_done;
        o_pending <= outcomes_due.size();
    end

endmodule

// ----- tb/nutrient_dosing_controller_tb.sv -----
// Testbench top for the nutrient dosing controller: makes clock, reset, register writes,
// bursty samples and a stalling result consumer, and gives the verdict.
// Depends on ndc_pkg, ndc_in_if, ndc_out_if, ndc_dose_checker and the block itself.
module nutrient_dosing_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ndc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    failures;
    int                    results_done;
    int                    pending;
    int                    sent;
    int                    quiet_cycles = 0;
    logic [TIME_W-1:0]     clock_ms;
    logic [DATA_W-1:0]     cur_threshold;

    ndc_in_if  reading_ch ();
    ndc_out_if result_ch ();

    nutrient_dosing_controller uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (reading_ch),
        .o_out      (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ndc_dose_checker dose_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in           (reading_ch),
        .i_out          (result_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_failures     (failures),
        .o_results_done (results_done),
        .o_pending      (pending)
    );

    always #4ns clk = ~clk;

    task automatic send_reading(input logic [DATA_W-1:0] level, input logic [TIME_W-1:0] stamp);
        reading_ch.valid <= 1'b1;
        reading_ch.sample <= level;
        reading_ch.now_ms <= stamp;
        do @(posedge clk); while (reading_ch.ready !== 1'b1);
        sent++;
    endtask

    task automatic await_results();
        reading_ch.valid <= 1'b0;
        while (results_done < sent) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] disp,
                                  input logic [DATA_W-1:0] mix);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_idx <= CFG_DISPENSE;
        cfg_data <= disp;
        @(posedge clk);
        cfg_idx <= CFG_MIX;
        cfg_data <= mix;
        @(posedge clk);
        cfg_idx <= CFG_SPARE;
        cfg_data <= CFG_DATA_W'($urandom());
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_threshold = thr;
    endtask

    task automatic advance_clock();
        case ($urandom_range(0, 19))
            0:       clock_ms = $urandom();
            1:       clock_ms = clock_ms - $urandom_range(1, 5000);
            2, 3:    clock_ms = clock_ms + $urandom_range(2000, 70000);
            4:       ;
            default: clock_ms = clock_ms + $urandom_range(0, 700);
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_level(input int regime);
        int below;
        below = int'(cur_threshold) - 1;
        case (regime)
            0:          return '0;
            1:          return DATA_W'($urandom());
            2:          return '1;
            3, 4, 5, 6: return (below >= 1) ? DATA_W'($urandom_range(1, below)) : '0;
            default:    return DATA_W'($urandom_range(int'(cur_threshold), 65535));
        endcase
    endfunction

    // Long hold-offs recur so that the block fills up while samples keep coming.
    initial begin
        int seg;
        int mode;
        int span;
        seg = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            seg++;
            if (seg % 12 == 3) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(300, 450)) @(posedge clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 300);
                repeat (span) begin
                    case (mode)
                        0:       result_ch.ready <= 1'b1;
                        1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                        2:       result_ch.ready <= ($urandom_range(0, 7) == 0);
                        default: result_ch.ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (reading_ch.valid && reading_ch.ready)
            || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int                burst;
        int                gap;
        int                left;
        int                regime;
        logic [DATA_W-1:0] thr;
        logic [DATA_W-1:0] disp;
        logic [DATA_W-1:0] mix;
        sent = 0;
        cur_threshold = THRESHOLD_RESET;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_THRESHOLD;
        cfg_data <= '0;
        reading_ch.valid <= 1'b0;
        reading_ch.sample <= '0;
        reading_ch.now_ms <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: a zero mean first, then a full-scale sample, then the
        // ring fills with low readings until dosing starts.
        send_reading(16'h0000, 32'h0000_0000);
        send_reading(16'hFFFF, 32'd250);
        clock_ms = 32'd250;
        repeat (17) begin
            clock_ms = clock_ms + 32'd400;
            send_reading(16'h0010, clock_ms);
        end
        // Timestamp at its top, wrapping round, then stepping backwards.
        send_reading(16'h0010, 32'hFFFF_FFFF);
        send_reading(16'h0010, 32'h0000_0100);
        send_reading(16'h0010, 32'h0000_0050);
        send_reading(16'h0010, 32'h0000_0060);
        await_results();
        // Zero dispense and mix times, with the highest threshold.
        apply_settings(16'hFFFF, 16'h0000, 16'h0000);
        repeat (3) send_reading(16'hFFFE, 32'h0000_0060);
        clock_ms = 32'h0000_0060;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    thr = 16'hFFFF;
                    disp = 16'd1;
                    mix = 16'd1;
                end
                1: begin
                    thr = 16'h0000;
                    disp = 16'hFFFF;
                    mix = 16'hFFFF;
                end
                2: begin
                    thr = THRESHOLD_RESET;
                    disp = DISPENSE_RESET;
                    mix = MIX_RESET;
                end
                default: begin
                    thr = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(1, 65535))
                                                      : DATA_W'($urandom_range(16, 8000));
                    disp = DATA_W'($urandom_range(1, 4000));
                    mix = DATA_W'($urandom_range(1, 12000));
                end
            endcase
            await_results();
            apply_settings(thr, disp, mix);
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                regime = $urandom_range(0, 9);
                while (burst > 0 && left > 0) begin
                    advance_clock();
                    send_reading(pick_level(regime), clock_ms);
                    burst--;
                    left--;
                end
                gap = (p == 3 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                if (gap > 0) begin
                    reading_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ndc_pkg.sv
src/ndc_in_if.sv
src/ndc_out_if.sv
src/nutrient_dosing_controller.sv
src/ndc_checker.sv
tb/ndc_dose_checker.sv
tb/nutrient_dosing_controller_tb.sv
